@@ hdl/cdd_pkg.sv @@
// Shared types and constants of the DAT packet deframer.
`timescale 1ns / 1ps
`default_nettype none
package cdd_pkg;

   localparam int MaxStreams = 16;
   localparam int SlotW      = (MaxStreams > 1) ? $clog2(MaxStreams) : 1;
   localparam int CntW       = $clog2(MaxStreams + 1);

   localparam logic [15:0] StartOffsetReset = 16'h2000;
   localparam logic [31:0] HdrMagic         = {8'h6C, 8'h69, 8'h75, 8'h20};
   localparam logic [6:0]  PosMagicEnd      = 7'd3;
   localparam logic [6:0]  PosIdent         = 7'd4;
   localparam logic [6:0]  PosWidth         = 7'd8;
   localparam logic [6:0]  PosHeight        = 7'd12;
   localparam logic [6:0]  PosRate          = 7'd16;
   localparam logic [6:0]  PosRateEnd       = 7'd20;
   localparam logic [6:0]  PosKey           = 7'd36;
   localparam logic [6:0]  PosKeyEnd        = 7'd40;
   localparam logic [6:0]  PosIndex         = 7'd44;
   localparam logic [6:0]  PosIndexEnd      = 7'd48;
   localparam logic [6:0]  PosPts           = 7'd52;
   localparam logic [6:0]  PosSize          = 7'd60;
   localparam logic [6:0]  PosSizeEnd       = 7'd64;
   localparam logic [6:0]  PosLast          = 7'd127;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_HEADER,
      PH_PAYLOAD,
      PH_HALT
   } phase_type;

   typedef enum logic [2:0] {
      KIND_PAYLOAD   = 3'd0,
      KIND_NEW       = 3'd1,
      KIND_BAD_MAGIC = 3'd2,
      KIND_END       = 3'd3,
      KIND_FULL      = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [3:0]  stream_slot;
      logic [31:0] stream_ident;
      logic [31:0] frame_width;
      logic [31:0] frame_height;
      logic [31:0] frame_rate;
      logic [63:0] timestamp;
      logic        key_frame;
      logic        first_byte;
      logic        last_byte;
      logic        index_warning;
   } result_type;

endpackage
`default_nettype wire

@@ hdl/cdd_queue.sv @@
// Two-entry result queue between the parser and the result channel.
`timescale 1ns / 1ps
`default_nettype none
module cdd_queue
   import cdd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_item,
   output logic            full,
   output logic            head_valid,
   output result_type      head_item,
   input  wire logic       pop
);

   result_type  mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

@@ hdl/cdd_front.sv @@
// Byte parser: preamble skip, header fields, stream table and result forming.
`timescale 1ns / 1ps
`default_nettype none
module cdd_front
   import cdd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        byte_valid,
   output logic             byte_ready,
   input  wire logic [7:0]  stream_byte,
   input  wire logic [15:0] start_offset,
   input  wire logic        queue_full,
   output logic             push,
   output result_type       push_item
);

   phase_type         phase_ff, phase_in;
   logic [15:0]       skip_ff, skip_in;
   logic [6:0]        pos_ff, pos_in;
   logic [31:0]       magic_ff, magic_in;
   logic [31:0]       ident_ff, ident_in;
   logic [31:0]       width_ff, width_in;
   logic [31:0]       height_ff, height_in;
   logic [31:0]       rate_ff, rate_in;
   logic              key_ff, key_in;
   logic [31:0]       index_ff, index_in;
   logic [63:0]       pts_ff, pts_in;
   logic [31:0]       left_ff, left_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic [SlotW-1:0]  slot_ff, slot_in;
   logic              first_ff, first_in;
   logic [31:0]       table_ff [MaxStreams];
   logic              table_we;

   logic              fire;
   logic              hdr_go;
   logic [6:0]        p;
   logic [2:0]        pts_sel;
   logic [MaxStreams-1:0] hit;
   logic              hit_any;
   logic [SlotW-1:0]  hit_slot;

   assign byte_ready = (phase_ff == PH_HALT) || !queue_full;
   assign fire       = byte_valid && byte_ready;

   always_comb begin
      hit_slot = '0;
      for (int i = 0; i < MaxStreams; i++) begin
         hit[i] = (CntW'(i) < count_ff) && (table_ff[i] == ident_ff);
      end
      for (int i = MaxStreams - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_slot = SlotW'(i);
         end
      end
      hit_any = |hit;
   end

   always_comb begin
      phase_in  = phase_ff;
      skip_in   = skip_ff;
      pos_in    = pos_ff;
      magic_in  = magic_ff;
      ident_in  = ident_ff;
      width_in  = width_ff;
      height_in = height_ff;
      rate_in   = rate_ff;
      key_in    = key_ff;
      index_in  = index_ff;
      pts_in    = pts_ff;
      left_in   = left_ff;
      count_in  = count_ff;
      slot_in   = slot_ff;
      first_in  = first_ff;
      table_we  = 1'b0;
      push      = 1'b0;
      push_item = '0;
      hdr_go    = 1'b0;
      p         = (phase_ff == PH_HEADER) ? pos_ff : '0;
      pts_sel   = 3'(p - PosPts);

      if (fire) begin
         unique case (phase_ff)
            PH_SKIP: begin
               if (skip_ff < start_offset) begin
                  skip_in = skip_ff + 16'd1;
               end else begin
                  phase_in = PH_HEADER;
                  hdr_go   = 1'b1;
               end
            end
            PH_HEADER: begin
               hdr_go = 1'b1;
            end
            PH_PAYLOAD: begin
               push                    = 1'b1;
               push_item.kind          = KIND_PAYLOAD;
               push_item.data_byte     = stream_byte;
               push_item.stream_slot   = 4'(slot_ff);
               push_item.timestamp     = pts_ff;
               push_item.key_frame     = key_ff;
               push_item.first_byte    = first_ff;
               push_item.last_byte     = (left_ff == 32'd1);
               push_item.index_warning = (index_ff >= 32'(count_ff));
               first_in                = 1'b0;
               left_in                 = left_ff - 32'd1;
               if (left_ff == 32'd1) begin
                  phase_in = PH_HEADER;
                  pos_in   = '0;
               end
            end
            PH_HALT: begin
            end
            default: begin
            end
         endcase
      end

      if (hdr_go) begin
         pos_in = p + 7'd1;
         if (p == '0) begin
            magic_in  = '0;
            ident_in  = '0;
            width_in  = '0;
            height_in = '0;
            rate_in   = '0;
            key_in    = 1'b0;
            index_in  = '0;
            pts_in    = '0;
            left_in   = '0;
         end
         priority if (p < PosIdent) begin
            magic_in = {magic_in[23:0], stream_byte};
            if (p == PosMagicEnd && magic_in != HdrMagic) begin
               phase_in       = PH_HALT;
               push           = 1'b1;
               push_item.kind = KIND_BAD_MAGIC;
            end
         end else if (p < PosWidth) begin
            ident_in[8*p[1:0] +: 8] = ident_in[8*p[1:0] +: 8] | stream_byte;
         end else if (p < PosHeight) begin
            width_in[8*p[1:0] +: 8] = width_in[8*p[1:0] +: 8] | stream_byte;
         end else if (p < PosRate) begin
            height_in[8*p[1:0] +: 8] = height_in[8*p[1:0] +: 8] | stream_byte;
         end else if (p < PosRateEnd) begin
            rate_in[8*p[1:0] +: 8] = rate_in[8*p[1:0] +: 8] | stream_byte;
         end else if (p == PosKey) begin
            key_in = (stream_byte == 8'd1);
         end else if (p > PosKey && p < PosKeyEnd) begin
            key_in = key_in && (stream_byte == 8'd0);
         end else if (p >= PosIndex && p < PosIndexEnd) begin
            index_in[8*p[1:0] +: 8] = index_in[8*p[1:0] +: 8] | stream_byte;
         end else if (p >= PosPts && p < PosSize) begin
            pts_in[8*pts_sel +: 8] = pts_in[8*pts_sel +: 8] | stream_byte;
         end else if (p >= PosSize && p < PosSizeEnd) begin
            left_in[8*p[1:0] +: 8] = left_in[8*p[1:0] +: 8] | stream_byte;
         end else begin
         end

         if (p == PosLast) begin
            priority if (left_ff == 32'd0) begin
               phase_in       = PH_HALT;
               push           = 1'b1;
               push_item.kind = KIND_END;
            end else if (hit_any) begin
               phase_in = PH_PAYLOAD;
               first_in = 1'b1;
               slot_in  = hit_slot;
            end else if (count_ff == CntW'(MaxStreams)) begin
               phase_in       = PH_HALT;
               push           = 1'b1;
               push_item.kind = KIND_FULL;
            end else begin
               phase_in               = PH_PAYLOAD;
               first_in               = 1'b1;
               table_we               = 1'b1;
               slot_in                = SlotW'(count_ff);
               count_in               = count_ff + CntW'(1);
               push                   = 1'b1;
               push_item.kind         = KIND_NEW;
               push_item.stream_slot  = 4'(count_ff);
               push_item.stream_ident = ident_ff;
               push_item.frame_width  = width_ff;
               push_item.frame_height = height_ff;
               push_item.frame_rate   = rate_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SKIP;
         skip_ff   <= '0;
         pos_ff    <= '0;
         magic_ff  <= '0;
         ident_ff  <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         rate_ff   <= '0;
         key_ff    <= 1'b0;
         index_ff  <= '0;
         pts_ff    <= '0;
         left_ff   <= '0;
         count_ff  <= '0;
         slot_ff   <= '0;
         first_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         skip_ff   <= skip_in;
         pos_ff    <= pos_in;
         magic_ff  <= magic_in;
         ident_ff  <= ident_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         rate_ff   <= rate_in;
         key_ff    <= key_in;
         index_ff  <= index_in;
         pts_ff    <= pts_in;
         left_ff   <= left_in;
         count_ff  <= count_in;
         slot_ff   <= slot_in;
         first_ff  <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (table_we) begin
         table_ff[count_ff[SlotW-1:0]] <= ident_ff;
      end
   end

endmodule
`default_nettype wire

@@ hdl/cctv_dat_packet_deframer_core.sv @@
// Top level of the DAT packet deframer: parser, result queue and ports.
//
// Usage:
//   req_* carries one container byte per item (valid/ready). The parser drops
//   csr_start_offset preamble bytes, then reads 128-byte headers, each
//   followed by its payload bytes.
//   rsp_* carries at most one result item per input byte: a payload byte,
//   a new-stream descriptor, or a status (bad magic, end marker, table full).
//   csr_* writes the preamble length; it is always ready and applies at once.
// Timing:
//   One byte per cycle while the queue is not full. A result is registered
//   in the queue when its byte is accepted; the stream-id compare is a
//   16-way parallel match done in the same cycle as the last header byte.
// Stalls:
//   A two-entry queue sits between parser and result port. When it is full
//   req_ready drops unless halted; header and preamble bytes stop as well.
// Reset:
//   Synchronous, active high. Clears the parser to the preamble phase, the
//   offset to 8192 and the stream count to zero. After a status item the
//   block accepts and ignores every byte until reset.
`timescale 1ns / 1ps
`default_nettype none
module cctv_dat_packet_deframer_core
   import cdd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_stream_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_kind,
   output logic [7:0]              rsp_data_byte,
   output logic [3:0]              rsp_stream_slot,
   output logic [31:0]             rsp_stream_ident,
   output logic [31:0]             rsp_frame_width,
   output logic [31:0]             rsp_frame_height,
   output logic [31:0]             rsp_frame_rate,
   output logic signed [63:0]      rsp_timestamp,
   output logic                    rsp_key_frame,
   output logic                    rsp_first_byte,
   output logic                    rsp_last_byte,
   output logic                    rsp_index_warning,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [15:0]        csr_start_offset
);

   logic [15:0] offset_ff, offset_in;
   logic        q_full;
   logic        q_push;
   result_type  q_push_item;
   result_type  head;

   assign csr_ready = 1'b1;
   assign offset_in = (csr_valid && csr_ready) ? csr_start_offset : offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= StartOffsetReset;
      end else begin
         offset_ff <= offset_in;
      end
   end

   cdd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_valid),
      .byte_ready   (req_ready),
      .stream_byte  (req_stream_byte),
      .start_offset (offset_ff),
      .queue_full   (q_full),
      .push         (q_push),
      .push_item    (q_push_item)
   );

   cdd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .head_valid (rsp_valid),
      .head_item  (head),
      .pop        (rsp_ready)
   );

   assign rsp_kind          = head.kind;
   assign rsp_data_byte     = head.data_byte;
   assign rsp_stream_slot   = head.stream_slot;
   assign rsp_stream_ident  = head.stream_ident;
   assign rsp_frame_width   = head.frame_width;
   assign rsp_frame_height  = head.frame_height;
   assign rsp_frame_rate    = head.frame_rate;
   assign rsp_timestamp     = $signed(head.timestamp);
   assign rsp_key_frame     = head.key_frame;
   assign rsp_first_byte    = head.first_byte;
   assign rsp_last_byte     = head.last_byte;
   assign rsp_index_warning = head.index_warning;

endmodule
`default_nettype wire
